>>> hw/rtl/assert_macros.svh
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold on the clock edge after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

`endif

>>> hw/rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

  // Store geometry.
  localparam int LIST_DEPTH    = 32;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = $clog2(LIST_DEPTH);
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  // Width that holds a position, a count and one more without overflow.
  localparam int CMP_W         = ((CNT_W > 6) ? CNT_W : 6) + 1;

  // Operation codes.
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_LOCATE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] value_out;
    logic [5:0]         found_position;
    logic [5:0]         list_length;
    logic               list_empty;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic scan_next;
    logic found_set;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_locate;
    logic cnt_zero;
    logic scan_hit;
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

  // Sign-extend a stored element to the 32-bit result field.
  function automatic logic signed [31:0] sext_elem(input elem_t e);
    logic signed [ELEMENT_WIDTH-1:0] s;
    s = signed'(e);
    return 32'(s);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ple_ctrl.sv
`default_nettype none

module ple_ctrl import ple_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       commit;
  logic       accept;

  // A request finishes in EXEC once the output register can take the result.
  assign commit   = (state_r == S_EXEC) && sts.out_free;
  assign in_stall = !((state_r == S_IDLE) || commit);
  assign accept   = in_valid && !in_stall;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd.load_req  = accept;
    cmd.scan_next = 1'b0;
    cmd.found_set = 1'b0;
    cmd.commit    = commit;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.in_locate ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_EXEC;
        end else if (sts.cnt_zero || sts.scan_last) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_EXEC: begin
        if (accept) begin
          state_nxt = sts.in_locate ? S_SCAN : S_EXEC;
        end else if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ple_dp.sv
`default_nettype none

module ple_dp import ple_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_item,
  input  wire logic     out_stall,
  output logic          out_valid,
  output out_item_t     out_item,
  input  wire ctl_cmd_t cmd,
  output ctl_sts_t      sts
);

  in_item_t             req_r;
  elem_t                store_r   [LIST_DEPTH];
  elem_t                store_nxt [LIST_DEPTH];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [IDX_W-1:0]     scan_idx_r;
  logic [CNT_W-1:0]     found_r;
  logic                 out_valid_r;
  out_item_t            out_r;
  out_item_t            res;

  logic [CMP_W-1:0]     pos_e;
  logic [CMP_W-1:0]     cnt_e;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W-1:0]     rd_addr;
  elem_t                rd_data;
  elem_t                req_val;
  logic                 ins_ok;
  logic                 rd_ok;
  logic                 ins_do;
  logic                 del_do;

  // Position checks against the current length.
  assign pos_e   = CMP_W'(req_r.position);
  assign cnt_e   = CMP_W'(count_r);
  assign pos_idx = IDX_W'(pos_e - CMP_W'(1));
  assign ins_ok  = (count_r < CNT_W'(LIST_DEPTH)) && (pos_e != '0) &&
                   (pos_e <= cnt_e + CMP_W'(1));
  assign rd_ok   = (pos_e != '0) && (pos_e <= cnt_e);
  assign req_val = ELEMENT_WIDTH'($unsigned(req_r.value_in));

  // One read port, shared by the locate scan and by get and delete.
  assign rd_addr = (req_r.kind == KIND_LOCATE) ? scan_idx_r : pos_idx;
  assign rd_data = store_r[rd_addr];

  assign ins_do = cmd.commit && (req_r.kind == KIND_INSERT) && ins_ok;
  assign del_do = cmd.commit && (req_r.kind == KIND_DELETE) && rd_ok;

  // Status toward the controller.
  always_comb begin
    sts.in_locate = (in_item.kind == KIND_LOCATE);
    sts.cnt_zero  = (count_r == '0);
    sts.scan_hit  = (rd_data == req_val) && (CNT_W'(scan_idx_r) < count_r);
    sts.scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) >= count_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // Result of the held request and the new length.
  always_comb begin
    res           = '0;
    count_nxt     = count_r;
    unique case (req_r.kind)
      KIND_INSERT: begin
        res.status = !ins_ok;
        if (ins_ok) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        res.status = !rd_ok;
        if (rd_ok) begin
          res.value_out = sext_elem(rd_data);
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      KIND_GET: begin
        res.status = !rd_ok;
        if (rd_ok) begin
          res.value_out = sext_elem(rd_data);
        end
      end
      KIND_LOCATE: begin
        res.found_position = 6'(found_r);
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.list_length = 6'(count_nxt);
    res.list_empty  = (count_nxt == '0);
  end

  // Shift the store up for insert or down for delete, one mux per entry.
  always_comb begin
    store_nxt = store_r;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (ins_do) begin
        if (IDX_W'(k) == pos_idx) begin
          store_nxt[IDX_W'(k)] = req_val;
        end else if (IDX_W'(k) > pos_idx) begin
          store_nxt[IDX_W'(k)] = store_r[IDX_W'(k - 1)];
        end
      end else if (del_do) begin
        if ((IDX_W'(k) >= pos_idx) && (k < LIST_DEPTH - 1)) begin
          store_nxt[IDX_W'(k)] = store_r[IDX_W'(k + 1)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  // Request register, scan index and match position.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r      <= in_item;
      scan_idx_r <= '0;
      found_r    <= '0;
    end else begin
      if (cmd.scan_next) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      if (cmd.found_set) begin
        found_r <= CNT_W'(scan_idx_r) + CNT_W'(1);
      end
    end
  end

  // Length register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to LIST_DEPTH signed words.
// Input channel (in_valid, in_stall, in_item) carries one request: insert,
// delete, get, locate or clear, with a 1-based position and a value. The
// result channel (out_valid, out_stall, out_item) returns exactly one result
// per request with status, value, match position, new length and empty flag.
// A request is taken at a clock edge where in_valid is high and in_stall low.
// Insert, delete, get and clear finish in EXEC once the output register is
// free; the result is visible from the following cycle, and a new request can
// be taken in the same cycle the previous one finishes, so these run at one
// per cycle while out_stall does not hold a result. Locate walks the store
// through its single read port, one entry per cycle, and stops at the first
// match, giving its 1-based position, or at the end of the list, giving 0.
// A finished result sits in the output register while out_stall is high; the
// next request may still be taken and worked on, but it cannot finish, and no
// further request is taken, until the output register is freed.
// Synchronous reset (rst_n low) empties the list and drops any pending result;
// the element store itself is not cleared, as only written entries are read.
`default_nettype none

`include "assert_macros.svh"

module positional_list_engine import ple_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Every finished request shows up as a pending result.
  `ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid)
  // A result never overwrites one that the receiver has not taken.
  `ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.commit && out_valid, !out_stall)
  // The scan never advances in the cycle a request finishes or a new one is taken.
  `ASSERT_SAME(a_scan_excl, clk, rst_n, cmd.scan_next, !cmd.commit && !cmd.load_req)
  // Reported length stays within the store and agrees with the empty flag.
  `ASSERT_SAME(a_len_ok, clk, rst_n, out_valid,
               (out_item.list_length <= 6'(LIST_DEPTH)) &&
               (out_item.list_empty == (out_item.list_length == 6'd0)))

endmodule

`default_nettype wire

>>> test/tb_positional_list_engine.sv
`timescale 1ns / 100ps

module tb_positional_list_engine;
  import ple_pkg::*;

  // Kind codes that the block answers with an error and otherwise ignores.
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_TICKS = 40;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int MAX_REPORTS  = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Shadow copy of the list contents and length.
  elem_t     shadow_list [LIST_DEPTH];
  int        shadow_len = 0;

  out_item_t pending_results [$];
  int        failures = 0;

  // Both sides stop idling while this is set.
  logic      steady_stream = 1'b0;
  // Long receiver hold-offs are requested by bumping this count.
  int        holds_requested = 0;
  int        holds_granted = 0;
  int        hold_left = 0;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Returns the 1-based position of the first entry equal to the value, or 0.
  function automatic int find_in_shadow(input elem_t value);
    for (int k = 0; k < shadow_len; k++) begin
      if (shadow_list[k] == value) return k + 1;
    end
    return 0;
  endfunction

  // Applies one request to the shadow list and returns the result it must give.
  function automatic out_item_t apply_list_request(input in_item_t req);
    out_item_t res;
    int        pos;
    res = '0;
    pos = int'(req.position);
    case (req.kind)
      KIND_INSERT: begin
        if (shadow_len >= LIST_DEPTH || pos < 1 || pos > shadow_len + 1) begin
          res.status = 1'b1;
        end else begin
          for (int k = shadow_len; k >= pos; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[pos - 1] = elem_t'(req.value_in);
          shadow_len++;
        end
      end
      KIND_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          res.status = 1'b1;
        end else begin
          res.value_out = 32'($signed(shadow_list[pos - 1]));
          for (int k = pos; k < shadow_len; k++) shadow_list[k - 1] = shadow_list[k];
          shadow_len--;
        end
      end
      KIND_GET: begin
        if (pos < 1 || pos > shadow_len) res.status = 1'b1;
        else res.value_out = 32'($signed(shadow_list[pos - 1]));
      end
      KIND_LOCATE: begin
        res.found_position = 6'(find_in_shadow(elem_t'(req.value_in)));
      end
      KIND_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        res.status = 1'b1;
      end
    endcase
    res.list_length = 6'(shadow_len);
    res.list_empty  = (shadow_len == 0);
    return res;
  endfunction

  // Builds a mostly well-formed request; grow_pct steers inserts against deletes.
  function automatic in_item_t make_request(input int grow_pct);
    in_item_t req;
    int       pick;
    req = '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: req.value_in = 32'sh7fff_ffff;
        1: req.value_in = 32'sh8000_0000;
        2: req.value_in = 32'sh0000_0000;
        default: req.value_in = 32'shffff_ffff;
      endcase
    end else if (pick < 3) begin
      // Small values repeat often, so locate has to pick the first match.
      req.value_in = 32'($urandom_range(0, 7));
    end else begin
      req.value_in = $urandom;
    end

    pick = $urandom_range(0, 99);
    if (pick < 3) req.kind = 3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
    else if (pick < 5) req.kind = KIND_CLEAR;
    else if (pick < 5 + (grow_pct * 6) / 10) req.kind = KIND_INSERT;
    else if (pick < 65) req.kind = KIND_DELETE;
    else if (pick < 82) req.kind = KIND_GET;
    else req.kind = KIND_LOCATE;

    // A few positions, and all for kinds past get, are anywhere; the rest in range if any.
    if ($urandom_range(0, 99) < 8 || req.kind > KIND_GET) begin
      req.position = 6'($urandom_range(0, 63));
    end else if (req.kind == KIND_INSERT) begin
      req.position = 6'($urandom_range(1, shadow_len + 1));
    end else if (shadow_len == 0) begin
      req.position = 6'($urandom_range(0, 63));
    end else begin
      req.position = 6'($urandom_range(1, shadow_len));
    end

    if (req.kind == KIND_LOCATE && shadow_len > 0 && $urandom_range(0, 99) < 60) begin
      req.value_in = shadow_list[$urandom_range(0, shadow_len - 1)];
    end
    return req;
  endfunction

  // Offers one request and records its expected result once the transfer happens.
  task automatic issue_request(input in_item_t req);
    while (!steady_stream && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_list_request(req));
  endtask

  task automatic send_op(input logic [2:0] kind, input logic [5:0] pos,
                         input logic signed [31:0] value);
    in_item_t req;
    req.kind     = kind;
    req.position = pos;
    req.value_in = value;
    issue_request(req);
  endtask

  // Stops offering and waits until every expected result is seen or the drain limit is hit.
  task automatic wait_for_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic test_directed_operations();
    // On an empty list get, delete and an insert off position 1 fail; locate does not.
    send_op(KIND_GET, 6'd1, 32'sd0);
    send_op(KIND_DELETE, 6'd1, 32'sd0);
    send_op(KIND_LOCATE, 6'd0, 32'sd0);
    send_op(KIND_INSERT, 6'd0, 32'sd1);
    send_op(KIND_INSERT, 6'd2, 32'sd1);
    // Build the list with the extreme values, inserting at front, back and middle.
    send_op(KIND_INSERT, 6'd1, 32'sh7fff_ffff);
    send_op(KIND_INSERT, 6'd2, 32'sh8000_0000);
    send_op(KIND_INSERT, 6'd1, 32'shffff_ffff);
    send_op(KIND_INSERT, 6'd2, 32'sd0);
    send_op(KIND_INSERT, 6'd63, 32'sd5);
    send_op(KIND_GET, 6'd4, 32'sd0);
    send_op(KIND_GET, 6'd5, 32'sd0);
    send_op(KIND_GET, 6'd0, 32'sd0);
    send_op(KIND_LOCATE, 6'd0, 32'sh7fff_ffff);
    send_op(KIND_LOCATE, 6'd0, 32'sd12345);
    // A duplicate at the end; locate must report the first copy.
    send_op(KIND_INSERT, 6'd5, 32'shffff_ffff);
    send_op(KIND_LOCATE, 6'd63, 32'shffff_ffff);
    send_op(KIND_DELETE, 6'd2, 32'sd0);
    send_op(KIND_DELETE, 6'd0, 32'sd0);
    send_op(KIND_DELETE, 6'd63, 32'sd0);
    for (int k = KIND_RESERVED_LO; k <= KIND_RESERVED_HI; k++) begin
      send_op(3'(k), 6'd63, 32'shffff_ffff);
    end
    send_op(KIND_CLEAR, 6'd0, 32'sd0);
    send_op(KIND_GET, 6'd1, 32'sd0);
    wait_for_idle();
  endtask

  task automatic test_full_list();
    logic signed [31:0] absent;
    send_op(KIND_CLEAR, 6'd0, 32'sd0);
    while (shadow_len < LIST_DEPTH) begin
      send_op(KIND_INSERT, 6'($urandom_range(1, shadow_len + 1)), $urandom);
    end
    // Inserts into a full list fail even at an otherwise legal position.
    send_op(KIND_INSERT, 6'(LIST_DEPTH + 1), $urandom);
    send_op(KIND_INSERT, 6'd1, $urandom);
    // The longest scans: a hit near the end and a miss over the whole list.
    send_op(KIND_LOCATE, 6'd0, shadow_list[LIST_DEPTH - 1]);
    do absent = $urandom; while (find_in_shadow(elem_t'(absent)) != 0);
    send_op(KIND_LOCATE, 6'd0, absent);
    send_op(KIND_GET, 6'(LIST_DEPTH), 32'sd0);
    send_op(KIND_GET, 6'(LIST_DEPTH + 1), 32'sd0);
    send_op(KIND_DELETE, 6'(LIST_DEPTH), 32'sd0);
    send_op(KIND_DELETE, 6'd1, 32'sd0);
    send_op(KIND_INSERT, 6'(shadow_len + 1), $urandom);
    wait_for_idle();
  endtask

  task automatic test_backpressure();
    // The receiver holds off while the sender keeps offering back to back.
    steady_stream   <= 1'b1;
    holds_requested <= holds_requested + 1;
    repeat (30) issue_request(make_request(50));
    steady_stream <= 1'b0;
    wait_for_idle();
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 1000; n++) begin
      // Middle stretch runs with no idling on either side.
      if (n == 400) steady_stream <= 1'b1;
      if (n == 600) steady_stream <= 1'b0;
      issue_request(make_request(((n / 100) % 2 == 0) ? 70 : 25));
    end
    wait_for_idle();
  endtask

  // Receiver: random stalls, a long counted hold-off on request, or none.
  always @(posedge clk) begin
    if (holds_granted != holds_requested) begin
      holds_granted <= holds_requested;
      hold_left     <= HOLD_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (steady_stream) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
    end
  end

  function automatic string show_result(input out_item_t r);
    return $sformatf("status=%0b value=%0d found=%0d length=%0d empty=%0b",
                     r.status, r.value_out, r.found_position, r.list_length, r.list_empty);
  endfunction

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    string     bad_fields;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("[%0t] result with nothing expected: %s", $time, show_result(out_item));
        end
      end else begin
        want = pending_results.pop_front();
        bad_fields = "";
        if (out_item.status !== want.status) bad_fields = {bad_fields, " status"};
        if (out_item.value_out !== want.value_out) bad_fields = {bad_fields, " value_out"};
        if (out_item.found_position !== want.found_position) begin
          bad_fields = {bad_fields, " found_position"};
        end
        if (out_item.list_length !== want.list_length) bad_fields = {bad_fields, " list_length"};
        if (out_item.list_empty !== want.list_empty) bad_fields = {bad_fields, " list_empty"};
        if (bad_fields != "") begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("[%0t] mismatch in%s", $time, bad_fields);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(out_item));
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_operations();
    test_full_list();
    test_backpressure();
    test_random_traffic();
    if (pending_results.size() != 0) begin
      failures += pending_results.size();
      $display("%0d expected results never arrived", pending_results.size());
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> positional_list_engine.f
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_ctrl.sv
hw/rtl/ple_dp.sv
hw/rtl/positional_list_engine.sv
test/tb_positional_list_engine.sv
